[design/afca_pkg.sv]
// ----------------------------------------------------------------------------
// afca_pkg: shared types and constants for the ADC frame coherence assembler
// Beat layouts for the event and result channels, operation codes, the
// millisecond reciprocal and the saturating counter helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package afca_pkg;

  // Operation codes carried in item_t.operation
  localparam logic [1:0] OP_COMPLETE = 2'd0;
  localparam logic [1:0] OP_ERROR    = 2'd1;
  localparam logic [1:0] OP_POP      = 2'd2;

  // floor(t / 1000) == (t * MS_RECIP) >> MS_SHIFT for every 32-bit t
  localparam int           MS_SHIFT = 38;
  localparam logic [28:0]  MS_RECIP = 29'd274877907;

  localparam logic [15:0]  COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  converter;
    logic        half;
    logic [31:0] timer_count;
  } item_t;

  typedef struct packed {
    logic        block_pushed;
    logic        block_dropped;
    logic        pop_valid;
    logic [31:0] pop_sequence;
    logic [22:0] pop_time_ms;
    logic [15:0] frame_errors;
    logic [15:0] drop_count;
    logic [15:0] converter_errors;
  } result_t;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == COUNT_MAX) ? v : v + 16'd1;
  endfunction

endpackage

[design/adc_frame_coherence_assembler.sv]
// ----------------------------------------------------------------------------
// adc_frame_coherence_assembler: double-buffer completion tracker
// Takes one event beat per unstalled cycle and returns exactly one result
// beat for it via the input and result registers. The timer is scaled to
// milliseconds by a reciprocal multiply ahead of the input register; all
// state (per-converter generations, per-half ready masks, the tag ring and
// the saturating counters) is read and updated in the single stage between
// the input register and the result register, so the sustained rate is one
// event per unstalled cycle. The tag ring has RING_SLOTS entries and holds
// at most RING_SLOTS - 1 tags; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module adc_frame_coherence_assembler #(
  parameter int NUM_CONVERTERS = 5,
  parameter int RING_SLOTS     = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  afca_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output afca_pkg::result_t result
);

  localparam int RING_W = $clog2(RING_SLOTS);
  localparam logic [NUM_CONVERTERS-1:0] ALL_READY = '1;
  localparam logic [RING_W-1:0] RING_LAST = RING_W'(RING_SLOTS - 1);

  // Handshake
  logic item_fire;
  logic s1_fire;
  logic out_free;

  // Input register
  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [2:0]  s1_conv;
  logic        s1_half;
  logic [22:0] s1_time_ms;
  logic [60:0] time_prod;

  // State
  logic [31:0]               conv_gen        [NUM_CONVERTERS];
  logic [31:0]               conv_gen_next   [NUM_CONVERTERS];
  logic [31:0]               half_gen        [2];
  logic [31:0]               half_gen_next   [2];
  logic [NUM_CONVERTERS-1:0] half_ready      [2];
  logic [NUM_CONVERTERS-1:0] half_ready_next [2];
  logic [31:0]               ring_seq        [RING_SLOTS];
  logic [22:0]               ring_time       [RING_SLOTS];
  logic [RING_W-1:0]         write_slot;
  logic [RING_W-1:0]         write_slot_next;
  logic [RING_W-1:0]         read_slot;
  logic [RING_W-1:0]         read_slot_next;
  logic [15:0]               frame_error_total;
  logic [15:0]               frame_error_total_next;
  logic [15:0]               drop_total;
  logic [15:0]               drop_total_next;
  logic [15:0]               error_event_total;
  logic [15:0]               error_event_total_next;

  // Completion datapath
  logic                      conv_known;
  logic [NUM_CONVERTERS-1:0] conv_bit;
  logic [31:0]               gen_cur;
  logic [31:0]               gen_new;
  logic                      parity_err;
  logic [NUM_CONVERTERS-1:0] ready_cur;
  logic                      restart;
  logic                      restart_err;
  logic [NUM_CONVERTERS-1:0] mask_kept;
  logic                      dup;
  logic [NUM_CONVERTERS-1:0] mask_set;
  logic                      block_done;
  logic [RING_W-1:0]         write_slot_inc;
  logic [RING_W-1:0]         read_slot_inc;
  logic                      ring_full;
  logic                      ring_empty;
  logic                      ring_we;
  logic [1:0]                fe_inc;
  logic [16:0]               fe_sum;
  afca_pkg::result_t         result_next;

  assign out_free   = !result_valid || !result_stall;
  assign s1_fire    = s1_valid && out_free;
  assign item_stall = s1_valid && !out_free;
  assign item_fire  = item_valid && !item_stall;

  assign time_prod = 61'(item.timer_count) * 61'(afca_pkg::MS_RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_fire) begin
      s1_op      <= item.operation;
      s1_conv    <= item.converter;
      s1_half    <= item.half;
      s1_time_ms <= time_prod[afca_pkg::MS_SHIFT +: 23];
    end
  end

  always_comb begin
    conv_known = 1'b0;
    gen_cur    = '0;
    conv_bit   = '0;
    for (int i = 0; i < NUM_CONVERTERS; i++) begin
      if (s1_conv == 3'(i)) begin
        conv_known  = 1'b1;
        gen_cur     = conv_gen[i];
        conv_bit[i] = 1'b1;
      end
    end
    gen_new     = gen_cur + 32'd1;
    parity_err  = gen_cur[0] != s1_half;
    ready_cur   = half_ready[s1_half];
    restart     = (ready_cur == '0) || (half_gen[s1_half] != gen_new);
    restart_err = restart && (ready_cur != '0);
    mask_kept   = restart ? '0 : ready_cur;
    dup         = |(mask_kept & conv_bit);
    mask_set    = (dup ? '0 : mask_kept) | conv_bit;
    block_done  = mask_set == ALL_READY;

    write_slot_inc = (write_slot == RING_LAST) ? '0 : write_slot + RING_W'(1);
    read_slot_inc  = (read_slot == RING_LAST) ? '0 : read_slot + RING_W'(1);
    ring_full      = write_slot_inc == read_slot;
    ring_empty     = read_slot == write_slot;

    conv_gen_next          = conv_gen;
    half_gen_next          = half_gen;
    half_ready_next        = half_ready;
    write_slot_next        = write_slot;
    read_slot_next         = read_slot;
    drop_total_next        = drop_total;
    error_event_total_next = error_event_total;
    ring_we                = 1'b0;
    fe_inc                 = 2'd0;
    result_next            = '0;

    case (s1_op)
      afca_pkg::OP_COMPLETE: begin
        if (conv_known) begin
          fe_inc = 2'(parity_err) + 2'(restart_err) + 2'(dup);
          for (int i = 0; i < NUM_CONVERTERS; i++) begin
            if (conv_bit[i]) begin
              conv_gen_next[i] = gen_new;
            end
          end
          if (restart) begin
            half_gen_next[s1_half] = gen_new;
          end
          half_ready_next[s1_half] = block_done ? '0 : mask_set;
          if (block_done) begin
            if (ring_full) begin
              drop_total_next           = afca_pkg::sat_inc(drop_total);
              result_next.block_dropped = 1'b1;
            end else begin
              ring_we                  = 1'b1;
              write_slot_next          = write_slot_inc;
              result_next.block_pushed = 1'b1;
            end
          end
        end
      end
      afca_pkg::OP_ERROR: begin
        error_event_total_next = afca_pkg::sat_inc(error_event_total);
        half_ready_next[0]     = '0;
        half_ready_next[1]     = '0;
      end
      afca_pkg::OP_POP: begin
        if (!ring_empty) begin
          result_next.pop_valid    = 1'b1;
          result_next.pop_sequence = ring_seq[read_slot];
          result_next.pop_time_ms  = ring_time[read_slot];
          read_slot_next           = read_slot_inc;
        end
      end
      default: begin
      end
    endcase

    // at most two frame errors per completion; saturate the sum
    fe_sum = {1'b0, frame_error_total} + 17'(fe_inc);
    frame_error_total_next = fe_sum[16] ? afca_pkg::COUNT_MAX : fe_sum[15:0];

    result_next.frame_errors     = frame_error_total_next;
    result_next.drop_count       = drop_total_next;
    result_next.converter_errors = error_event_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CONVERTERS; i++) begin
        conv_gen[i] <= '0;
      end
      half_gen[0]       <= '0;
      half_gen[1]       <= '0;
      half_ready[0]     <= '0;
      half_ready[1]     <= '0;
      write_slot        <= '0;
      read_slot         <= '0;
      frame_error_total <= '0;
      drop_total        <= '0;
      error_event_total <= '0;
    end else if (s1_fire) begin
      conv_gen          <= conv_gen_next;
      half_gen          <= half_gen_next;
      half_ready        <= half_ready_next;
      write_slot        <= write_slot_next;
      read_slot         <= read_slot_next;
      frame_error_total <= frame_error_total_next;
      drop_total        <= drop_total_next;
      error_event_total <= error_event_total_next;
    end
  end

  // Tag ring storage: written only at the write slot, no reset
  always_ff @(posedge clk) begin
    if (s1_fire && ring_we) begin
      ring_seq[write_slot]  <= gen_new;
      ring_time[write_slot] <= s1_time_ms;
    end
  end

  // Result register: advance whenever the downstream beat is taken or absent
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      result <= result_next;
    end
  end

  a_push_xor_drop: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(result.block_pushed && result.block_dropped))
    else $error("block both pushed and dropped");

  a_empty_pop_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.pop_valid) |->
      (result.pop_sequence == 32'd0 && result.pop_time_ms == 23'd0))
    else $error("pop fields nonzero without a tag");

  a_fe_monotonic: assert property (@(posedge clk) disable iff (rst)
    s1_fire |=> frame_error_total >= $past(frame_error_total))
    else $error("frame error count went down");

  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> !item_stall)
    else $error("stall raised with an empty input register");

endmodule
